// ===== rtl/core/ffa_pkg.sv =====
// Shared types and codes of the first-fit free-list allocator.
package ffa_pkg;

	// Operation codes carried in the input tuser field.
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_FIT   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_DOUBLE   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;
	localparam logic [2:0] ST_NOT_INIT = 3'd5;

	// Configuration register indexes.
	localparam logic [7:0] REG_R0_BASE = 8'd0;
	localparam logic [7:0] REG_R0_LEN  = 8'd1;
	localparam logic [7:0] REG_R1_BASE = 8'd2;
	localparam logic [7:0] REG_R1_LEN  = 8'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT0,
		S_INIT1,
		S_ALLOC,
		S_WALK_RD,
		S_WALK_EV,
		S_SPLIT,
		S_ADDR,
		S_FREE_SCAN,
		S_FREE_END,
		S_DONE
	} ffa_state_t;

	// Per-field write enables of the block table.
	typedef struct packed {
		logic start;
		logic bytes;
		logic handed;
		logic link;
	} ffa_wr_t;

endpackage

// ===== rtl/core/ffa_table.sv =====
// Block table memories: start, length, handed-out address and free-list link.
module ffa_table import ffa_pkg::*; #(
	parameter int MAX_BLOCKS = 16,
	parameter int IW0 = $clog2(MAX_BLOCKS),
	parameter int IW = $clog2(MAX_BLOCKS + 1)
) (
	input  logic           clk,
	input  ffa_wr_t        wr,
	input  logic [IW0-1:0] wr_idx,
	input  logic [31:0]    wr_start,
	input  logic [31:0]    wr_bytes,
	input  logic [31:0]    wr_handed,
	input  logic [IW-1:0]  wr_link,
	input  logic [IW0-1:0] rd_idx,
	output logic [31:0]    rd_start,
	output logic [31:0]    rd_bytes,
	output logic [31:0]    rd_handed,
	output logic [IW-1:0]  rd_link
);

	logic [31:0]   start_mem  [MAX_BLOCKS];
	logic [31:0]   bytes_mem  [MAX_BLOCKS];
	logic [31:0]   handed_mem [MAX_BLOCKS];
	logic [IW-1:0] link_mem   [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.start) start_mem[wr_idx] <= wr_start;
		if (wr.bytes) bytes_mem[wr_idx] <= wr_bytes;
		if (wr.handed) handed_mem[wr_idx] <= wr_handed;
		if (wr.link) link_mem[wr_idx] <= wr_link;
		rd_start  <= start_mem[rd_idx];
		rd_bytes  <= bytes_mem[rd_idx];
		rd_handed <= handed_mem[rd_idx];
		rd_link   <= link_mem[rd_idx];
	end

endmodule

// ===== rtl/core/first_fit_free_list_allocator_top.sv =====
// Top level of the first-fit free-list allocator with its sequencer.
//
//  Channel  Signals                        Beat contents (lowest bit first)
//  s_*      s_tvalid s_tready s_tdata s_tuser  tdata: request_size, release_address
//                                              tuser: operation, want_aligned
//  m_*      m_tvalid m_tready m_tdata m_tuser  tdata: granted_address
//                                              tuser: status
//  cfg_*    cfg_valid cfg_ready cfg_index cfg_data  register write, always ready
//
// One item is worked at a time; s_tready is high only while the sequencer is idle.
// Init writes the two region entries in turn. Allocate walks the free list entry by
// entry, and a split adds a step that writes the split-off entry; the table has one
// read port and each list step waits for its registered read. Free scans every table
// entry through that port. The sequencer returns to idle after the result is loaded,
// before the next beat can be accepted.
// The result sits in an output register, so a stalled m_tready holds only the next
// result, not the next accept.
// Reset clears the valid bits, the list head and the initialized flag; the table
// memories are not cleared and need no clearing pass. PAGE_BYTES must be a power of two; the block does not enforce it.
module first_fit_free_list_allocator_top import ffa_pkg::*; #(
	parameter int MAX_BLOCKS = 16,
	parameter int HEADER_BYTES = 20,
	parameter int PAGE_BYTES = 4096,
	parameter int FIT_SLACK = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] request_size, [63:32] release_address
	input  logic [7:0]  s_tuser,   // [1:0] operation, [2] want_aligned, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] granted_address
	output logic [7:0]  m_tuser,   // [2:0] status, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW0 = $clog2(MAX_BLOCKS);
	localparam int IW = $clog2(MAX_BLOCKS + 1);
	localparam logic [IW-1:0] NULL_IDX = IW'(MAX_BLOCKS);
	localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
	localparam logic [33:0] PAGE34 = 34'(PAGE_BYTES);
	localparam logic [34:0] SLACK35 = 35'(HEADER_BYTES + FIT_SLACK);
	localparam logic [31:0] PMASK = ~(32'(PAGE_BYTES) - 32'd1);

	ffa_state_t state_q, state_d;

	logic [31:0] r0_base_q, r0_len_q, r1_base_q, r1_len_q;
	logic [MAX_BLOCKS-1:0] valid_q, in_use_q;
	logic [IW-1:0] head_q, cur_q, prev_q, steps_q, scan_q;
	logic ready_flag_q;
	logic aligned_q;
	logic [33:0] real_q;
	logic [34:0] limit_q;
	logic [31:0] rel_q, newb_q, start_q, base_q;
	logic [IW0-1:0] slot_q, used_q, hit_idx_q, cmp_idx_s1;
	logic hit_q, dbl_q, cmp_v_s1;
	logic [31:0] res_addr_q;
	logic [2:0] res_status_q;
	logic m_valid_q;
	logic [31:0] m_addr_q;
	logic [2:0] m_status_q;

	// Table port signals.
	ffa_wr_t wr;
	logic [IW0-1:0] wr_idx, rd_idx;
	logic [31:0] wr_start, wr_bytes, wr_handed;
	logic [IW-1:0] wr_link;
	logic [31:0] rd_start, rd_bytes, rd_handed;
	logic [IW-1:0] rd_link;

	ffa_table #(.MAX_BLOCKS(MAX_BLOCKS), .IW0(IW0), .IW(IW)) u_table (
		.clk(clk), .wr(wr), .wr_idx(wr_idx), .wr_start(wr_start), .wr_bytes(wr_bytes),
		.wr_handed(wr_handed), .wr_link(wr_link), .rd_idx(rd_idx), .rd_start(rd_start),
		.rd_bytes(rd_bytes), .rd_handed(rd_handed), .rd_link(rd_link)
	);

	logic accept;
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_addr_q;
	assign m_tuser = {5'd0, m_status_q};

	// First table entry that is not valid, used as the slot of a split tail.
	logic free_found;
	logic [IW0-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IW0'(i);
			end
		end
	end

	// Walk decisions on the registered read of the current entry.
	logic fits, near_exact, cur_live, scan_issue;
	logic [31:0] split_base, grant_addr;
	assign cur_live = (cur_q < NULL_IDX) && (steps_q < NULL_IDX);
	assign fits = {2'b00, rd_bytes} >= real_q;
	assign near_exact = {3'b000, rd_bytes} <= limit_q;
	assign split_base = start_q + newb_q;
	assign grant_addr = aligned_q ? ((base_q & PMASK) + 32'(PAGE_BYTES))
	                              : (base_q + 32'(HEADER_BYTES));
	assign scan_issue = (state_q == S_FREE_SCAN) && (scan_q < NULL_IDX);

	logic init_first, init_second;
	assign init_first = (r0_len_q != 32'd0);
	assign init_second = (r1_len_q != 32'd0);

	always_comb begin
		state_d = state_q;
		wr = '0;
		wr_idx = '0;
		wr_start = '0;
		wr_bytes = '0;
		wr_handed = '0;
		wr_link = NULL_IDX;
		rd_idx = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser[1:0])
						OP_INIT: state_d = S_INIT0;
						OP_ALLOC: state_d = ready_flag_q ? S_ALLOC : S_DONE;
						OP_FREE: state_d = ready_flag_q ? S_FREE_SCAN : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_INIT0: begin
				wr = '{start: init_first, bytes: init_first, handed: init_first,
				       link: init_first};
				wr_start = r0_base_q;
				wr_bytes = r0_len_q;
				wr_link = init_second ? IW'(1) : NULL_IDX;
				state_d = S_INIT1;
			end
			S_INIT1: begin
				wr = '{start: init_second, bytes: init_second, handed: init_second,
				       link: init_second};
				wr_idx = init_first ? IW0'(1) : '0;
				wr_start = r1_base_q;
				wr_bytes = r1_len_q;
				state_d = S_DONE;
			end
			S_ALLOC: state_d = S_WALK_RD;
			S_WALK_RD: begin
				rd_idx = cur_q[IW0-1:0];
				state_d = cur_live ? S_WALK_EV : S_DONE;
			end
			S_WALK_EV: begin
				if (!fits) begin
					state_d = S_WALK_RD;
				end else if (near_exact) begin
					// Unlink the whole block; a head unlink needs no table write.
					wr.link = (prev_q != NULL_IDX);
					wr_idx = prev_q[IW0-1:0];
					wr_link = rd_link;
					state_d = S_ADDR;
				end else if (free_found) begin
					wr.bytes = 1'b1;
					wr_idx = cur_q[IW0-1:0];
					wr_bytes = rd_bytes - real_q[31:0];
					state_d = S_SPLIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SPLIT: begin
				wr.start = 1'b1;
				wr.bytes = 1'b1;
				wr_idx = slot_q;
				wr_start = split_base;
				wr_bytes = real_q[31:0];
				state_d = S_ADDR;
			end
			S_ADDR: begin
				wr.handed = 1'b1;
				wr_idx = used_q;
				wr_handed = grant_addr;
				state_d = S_DONE;
			end
			S_FREE_SCAN: begin
				rd_idx = scan_q[IW0-1:0];
				if (!scan_issue && !cmp_v_s1) state_d = S_FREE_END;
			end
			S_FREE_END: begin
				wr.link = hit_q;
				wr_idx = hit_idx_q;
				wr_link = head_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_base_q <= '0;
			r0_len_q <= '0;
			r1_base_q <= '0;
			r1_len_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_R0_BASE: r0_base_q <= cfg_data;
				REG_R0_LEN: r0_len_q <= cfg_data;
				REG_R1_BASE: r1_base_q <= cfg_data;
				REG_R1_LEN: r1_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state: valid and in-use bits, list head, flags and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			in_use_q <= '0;
			head_q <= NULL_IDX;
			ready_flag_q <= 1'b0;
			m_valid_q <= 1'b0;
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= scan_issue;
			// A new result may load in the same cycle that the old one leaves.
			if (state_q == S_DONE && (!m_valid_q || m_tready)) m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			case (state_q)
				S_INIT0: begin
					valid_q <= {{(MAX_BLOCKS-1){1'b0}}, init_first || init_second};
					in_use_q <= '0;
					head_q <= (init_first || init_second) ? '0 : NULL_IDX;
				end
				S_INIT1: begin
					if (init_first && init_second) valid_q[1] <= 1'b1;
					ready_flag_q <= 1'b1;
				end
				S_WALK_EV: begin
					if (fits && near_exact) begin
						in_use_q[cur_q[IW0-1:0]] <= 1'b1;
						if (prev_q == NULL_IDX) head_q <= rd_link;
					end
				end
				S_SPLIT: begin
					valid_q[slot_q] <= 1'b1;
					in_use_q[slot_q] <= 1'b1;
				end
				S_FREE_END: begin
					if (hit_q) begin
						in_use_q[hit_idx_q] <= 1'b0;
						head_q <= IW'(hit_idx_q);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q[IW0-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					aligned_q <= s_tuser[2];
					real_q <= {2'b00, s_tdata[31:0]} + HDR34 + (s_tuser[2] ? PAGE34 : '0);
					rel_q <= s_tdata[63:32];
					cur_q <= head_q;
					prev_q <= NULL_IDX;
					steps_q <= '0;
					scan_q <= '0;
					hit_q <= 1'b0;
					dbl_q <= 1'b0;
					res_addr_q <= '0;
					res_status_q <= (s_tuser[1:0] == OP_ALLOC || s_tuser[1:0] == OP_FREE)
					                ? ST_NOT_INIT : ST_OK;
				end
			end
			S_ALLOC: begin
				limit_q <= {1'b0, real_q} + SLACK35;
				res_status_q <= ST_NO_FIT;
			end
			S_WALK_EV: begin
				if (!fits) begin
					prev_q <= cur_q;
					cur_q <= rd_link;
					steps_q <= steps_q + IW'(1);
				end else if (near_exact) begin
					used_q <= cur_q[IW0-1:0];
					base_q <= rd_start;
				end else if (free_found) begin
					newb_q <= rd_bytes - real_q[31:0];
					start_q <= rd_start;
					slot_q <= free_idx;
				end else begin
					res_status_q <= ST_FULL;
				end
			end
			S_SPLIT: begin
				used_q <= slot_q;
				base_q <= split_base;
			end
			S_ADDR: begin
				res_addr_q <= grant_addr;
				res_status_q <= ST_OK;
			end
			S_FREE_SCAN: begin
				if (scan_issue) scan_q <= scan_q + IW'(1);
				if (cmp_v_s1 && valid_q[cmp_idx_s1] && rd_handed == rel_q) begin
					if (in_use_q[cmp_idx_s1]) begin
						if (!hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cmp_idx_s1;
						end
					end else begin
						dbl_q <= 1'b1;
					end
				end
			end
			S_FREE_END: begin
				if (hit_q) res_status_q <= ST_OK;
				else if (rel_q != 32'd0 && dbl_q) res_status_q <= ST_DOUBLE;
				else res_status_q <= ST_UNKNOWN;
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					m_addr_q <= res_addr_q;
					m_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

endmodule
